// ----- hdl/lzwe_pkg.sv -----
// ----------------------------------------------------------------------------
// LZW encoder package
// Shared constants, including the table size bounds, and the sequencer state type.
// ----------------------------------------------------------------------------
package lzwe_pkg;

   localparam int MAX_TABLE_BITS_DEFAULT = 16;
   localparam int MIN_TABLE_BITS         = 12;
   localparam int EPOCH_BITS             = 16;

   localparam logic [15:0] EOF_CODE      = 16'd256;
   localparam logic [16:0] FIRST_CODE    = 17'd257;
   localparam logic [17:0] RESTART_EXTRA = 18'd4096;
   localparam logic [4:0]  START_WIDTH   = 5'd9;
   localparam logic [16:0] START_LIMIT   = 17'd512;
   localparam logic [4:0]  TABLE_BITS_RESET = 5'd16;

   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_HEAD_WAIT,
      ST_COMPARE,
      ST_MISS,
      ST_END_PREFIX,
      ST_END_EOF,
      ST_CLEAR
   } state_type;

endpackage

// ----- hdl/lzwe_ram.sv -----
// ----------------------------------------------------------------------------
// LZW encoder RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module lzwe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hdl/lzw_variable_width_encoder_core.sv -----
// ----------------------------------------------------------------------------
// LZW variable width encoder core
// Byte stream LZW compressor that walks per-prefix child chains in memory.
// ----------------------------------------------------------------------------
// Usage: bytes enter on the req_ channel (req_opcode data or end of stream),
// codes leave on the rsp_ channel with their bit width and a last flag on the
// end-of-file code. csr_wr_en writes the table size (log2); the user must do so
// only while idle, as the block does not enforce it. A data byte that opens a
// stream is taken at once; any other byte passes ST_HEAD and ST_HEAD_WAIT, then
// one compare per dictionary probe along the prefix's child chain, at one probe
// a cycle, plus ST_MISS on a miss. An end item that closes a nonempty stream
// passes ST_END_PREFIX and ST_END_EOF, plus output waits. req_stall is high
// while an item is in work. Results sit in one output register; when rsp_stall
// holds it, the sequencer waits before loading the next result, and nothing
// is lost. Reset (synchronous) empties the stream and starts a clearing pass
// over the chain heads, with req_stall high.
// Restarts of the dictionary bump an epoch mark on the chain heads instead;
// when that mark wraps around, the same clearing pass runs again.
// ----------------------------------------------------------------------------
module lzw_variable_width_encoder_core #(
   parameter int MAX_TABLE_BITS = lzwe_pkg::MAX_TABLE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code,
   output logic [4:0]  rsp_code_width,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);

   import lzwe_pkg::*;

   localparam int AW    = MAX_TABLE_BITS;
   localparam int DEPTH = 1 << MAX_TABLE_BITS;
   localparam int NW    = AW + 1;
   localparam int HW    = EPOCH_BITS + NW;

   state_type state_ff, state_in;
   logic [4:0]            tsb_ff;
   logic [15:0]           prefix_ff, prefix_in;
   logic                  pvalid_ff, pvalid_in;
   logic [16:0]           next_ff, next_in;
   logic [4:0]            width_ff, width_in;
   logic [16:0]           wlim_ff, wlim_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [7:0]            byte_ff, byte_in;
   logic [NW-1:0]         node_ff, node_in;
   logic [NW-1:0]         head_ff, head_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_code_ff, rsp_code_in;
   logic [4:0]            rsp_width_ff, rsp_width_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [AW-1:0] head_rd_addr, node_rd_addr;
   logic [HW-1:0] head_rd_data;
   logic [23:0]   dict_rd_data;
   logic [NW-1:0] sib_rd_data;
   logic          def_we;
   logic          clearing;
   logic          head_we;
   logic [AW-1:0] head_wr_addr;
   logic [HW-1:0] head_wr_data;
   logic          epoch_wrap;
   logic [4:0]    tsb_eff;
   logic [17:0]   limit;
   logic          out_free;
   logic          req_take;
   logic [NW-1:0] head_val;
   logic          key_hit;
   logic          can_define;
   logic          restart;

   // Chain head write port: defines, or zeroes during the clearing pass.
   assign clearing     = (state_ff == ST_CLEAR);
   assign head_we      = def_we || clearing;
   assign head_wr_addr = clearing ? clr_ff : prefix_ff[AW-1:0];
   assign head_wr_data = clearing ? '0 : {epoch_ff, next_ff[AW-1:0] + NW'(1)};

   // Chain heads carry an epoch tag; dictionary and sibling share one address.
   lzwe_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_addr (head_rd_addr),
      .rd_data (head_rd_data)
   );

   lzwe_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_dict_ram (
      .clock   (clock),
      .wr_en   (def_we),
      .wr_addr (next_ff[AW-1:0]),
      .wr_data ({prefix_ff, byte_ff}),
      .rd_addr (node_rd_addr),
      .rd_data (dict_rd_data)
   );

   lzwe_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_sib_ram (
      .clock   (clock),
      .wr_en   (def_we),
      .wr_addr (next_ff[AW-1:0]),
      .wr_data (head_ff),
      .rd_addr (node_rd_addr),
      .rd_data (sib_rd_data)
   );

   // Effective table size and restart bound.
   always_comb begin
      if (tsb_ff < 5'(MIN_TABLE_BITS)) begin
         tsb_eff = 5'(MIN_TABLE_BITS);
      end else if (tsb_ff > 5'(MAX_TABLE_BITS)) begin
         tsb_eff = 5'(MAX_TABLE_BITS);
      end else begin
         tsb_eff = tsb_ff;
      end
      limit = 18'd1 << tsb_eff;
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign head_val   = (head_rd_data[HW-1:NW] == epoch_ff) ? head_rd_data[NW-1:0] : '0;
   assign key_hit    = (dict_rd_data == {prefix_ff, byte_ff});
   assign can_define = ({1'b0, next_ff} < limit);
   assign restart    = ({1'b0, next_ff} >= limit + RESTART_EXTRA);
   assign def_we     = (state_ff == ST_MISS) && out_free && can_define;
   assign epoch_wrap = (epoch_ff == '1);

   // Read addresses: chain head by prefix, then probe node by code.
   always_comb begin
      head_rd_addr = prefix_ff[AW-1:0];
      if (state_ff == ST_HEAD_WAIT) begin
         node_rd_addr = head_val[AW-1:0] - AW'(1);
      end else begin
         node_rd_addr = sib_rd_data[AW-1:0] - AW'(1);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_opcode == OP_END) begin
                  if (pvalid_ff) begin
                     state_in = ST_END_PREFIX;
                  end else begin
                     state_in = epoch_wrap ? ST_CLEAR : ST_IDLE;
                  end
               end else if (pvalid_ff) begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_HEAD:      state_in = ST_HEAD_WAIT;
         ST_HEAD_WAIT: state_in = (head_val == '0) ? ST_MISS : ST_COMPARE;
         ST_COMPARE: begin
            if (key_hit) begin
               state_in = ST_IDLE;
            end else if (sib_rd_data == '0) begin
               state_in = ST_MISS;
            end
         end
         ST_MISS: begin
            if (out_free) begin
               state_in = (restart && epoch_wrap) ? ST_CLEAR : ST_IDLE;
            end
         end
         ST_END_PREFIX: if (out_free) state_in = ST_END_EOF;
         ST_END_EOF: begin
            if (out_free) begin
               state_in = epoch_wrap ? ST_CLEAR : ST_IDLE;
            end
         end
         ST_CLEAR:      if (clr_ff == '1) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath and result register updates.
   always_comb begin
      prefix_in    = prefix_ff;
      pvalid_in    = pvalid_ff;
      next_in      = next_ff;
      width_in     = width_ff;
      wlim_in      = wlim_ff;
      epoch_in     = epoch_ff;
      clr_in       = clr_ff;
      byte_in      = byte_ff;
      node_in      = node_ff;
      head_in      = head_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_code_in  = rsp_code_ff;
      rsp_width_in = rsp_width_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               byte_in = req_data_byte;
               if (req_opcode == OP_END) begin
                  if (!pvalid_ff) begin
                     prefix_in = '0;
                     next_in   = FIRST_CODE;
                     width_in  = START_WIDTH;
                     wlim_in   = START_LIMIT;
                     epoch_in  = epoch_ff + EPOCH_BITS'(1);
                  end
               end else if (!pvalid_ff) begin
                  prefix_in = {8'd0, req_data_byte};
                  pvalid_in = 1'b1;
               end
            end
         end
         ST_HEAD_WAIT: begin
            head_in = head_val;
            node_in = head_val;
         end
         ST_COMPARE: begin
            if (key_hit) begin
               prefix_in = 16'(node_ff - NW'(1));
            end else begin
               node_in = sib_rd_data;
            end
         end
         ST_MISS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = prefix_ff;
               rsp_width_in = width_ff;
               rsp_last_in  = 1'b0;
               if (can_define && (next_ff == wlim_ff)) begin
                  width_in = width_ff + 5'd1;
                  wlim_in  = {wlim_ff[15:0], 1'b0};
               end
               if (restart) begin
                  next_in  = FIRST_CODE;
                  width_in = START_WIDTH;
                  wlim_in  = START_LIMIT;
                  epoch_in = epoch_ff + EPOCH_BITS'(1);
               end else begin
                  next_in = next_ff + 17'd1;
               end
               prefix_in = {8'd0, byte_ff};
            end
         end
         ST_END_PREFIX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = prefix_ff;
               rsp_width_in = width_ff;
               rsp_last_in  = 1'b0;
            end
         end
         ST_END_EOF: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = EOF_CODE;
               rsp_width_in = width_ff;
               rsp_last_in  = 1'b1;
               prefix_in    = '0;
               pvalid_in    = 1'b0;
               next_in      = FIRST_CODE;
               width_in     = START_WIDTH;
               wlim_in      = START_LIMIT;
               epoch_in     = epoch_ff + EPOCH_BITS'(1);
            end
         end
         ST_CLEAR: begin
            // The counter wraps back to zero at the end of the pass.
            clr_in = clr_ff + AW'(1);
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         tsb_ff       <= TABLE_BITS_RESET;
         prefix_ff    <= '0;
         pvalid_ff    <= 1'b0;
         next_ff      <= FIRST_CODE;
         width_ff     <= START_WIDTH;
         wlim_ff      <= START_LIMIT;
         epoch_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prefix_ff    <= prefix_in;
         pvalid_ff    <= pvalid_in;
         next_ff      <= next_in;
         width_ff     <= width_in;
         wlim_ff      <= wlim_in;
         epoch_ff     <= epoch_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            tsb_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      node_ff      <= node_in;
      head_ff      <= head_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_width_ff <= rsp_width_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code       = rsp_code_ff;
   assign rsp_code_width = rsp_width_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ----- tb/lzw_variable_width_encoder_core_test.sv -----
// ----------------------------------------------------------------------------
// LZW variable width encoder core testbench
// Sends directed and random byte streams. A behavioral LZW model predicts
// every emitted code, and each code is checked field by field. Both sides of
// the link idle at random, and the dictionary is run through several table
// sizes and through code width growth.
// ----------------------------------------------------------------------------
module lzw_variable_width_encoder_core_test;
   import lzwe_pkg::*;

   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int SETTLE_CYCLES = 800;

   typedef struct packed {
      logic [15:0] code;
      logic [4:0]  code_width;
      logic        last;
   } code_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_code;
   logic [4:0]  rsp_code_width;
   logic        rsp_last;
   logic        csr_wr_en;
   logic [4:0]  csr_wr_data;

   // Model state of the encoder.
   code_word_type pending_codes[$];
   int          pair_codes[int];
   logic [4:0]  table_bits_reg;
   int          prefix;
   bit          prefix_seen;
   int          next_code;
   int          cur_width;
   int          width_limit;

   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_off_cycles;
   int          cycles;
   int          errors;
   int          bytes_sent;
   int          codes_checked;
   int          max_width_seen;

   lzw_variable_width_encoder_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort the run if it hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // The receiver stalls at random, or for a long stretch on request.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Each code transfer is compared with the oldest predicted code.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_codes.size() == 0) begin
            $error("unexpected code %0d", rsp_code);
            errors++;
         end else begin
            code_word_type exp_word;
            exp_word = pending_codes.pop_front();
            codes_checked++;
            if (rsp_code !== exp_word.code) begin
               $error("code: expected %0d, actual %0d", exp_word.code, rsp_code);
               errors++;
            end
            if (rsp_code_width !== exp_word.code_width) begin
               $error("code_width: expected %0d, actual %0d",
                      exp_word.code_width, rsp_code_width);
               errors++;
            end
            if (rsp_last !== exp_word.last) begin
               $error("last: expected %0d, actual %0d", exp_word.last, rsp_last);
               errors++;
            end
         end
      end
   end

   function automatic void clear_dictionary();
      pair_codes.delete();
      next_code = FIRST_CODE;
      cur_width = START_WIDTH;
      width_limit = START_LIMIT;
   endfunction

   function automatic void push_code(int code, bit last);
      code_word_type w;
      w.code = code[15:0];
      w.code_width = cur_width[4:0];
      w.last = last;
      pending_codes.push_back(w);
      if (cur_width > max_width_seen) max_width_seen = cur_width;
   endfunction

   // Advance the encoder model by one accepted item.
   function automatic void predict_codes(logic op, logic [7:0] data);
      int tbits;
      int table_codes;
      int key;
      tbits = table_bits_reg;
      if (tbits < MIN_TABLE_BITS) tbits = MIN_TABLE_BITS;
      if (tbits > MAX_TABLE_BITS_DEFAULT) tbits = MAX_TABLE_BITS_DEFAULT;
      table_codes = 1 << tbits;
      if (op == OP_END) begin
         if (prefix_seen) begin
            push_code(prefix, 1'b0);
            push_code(EOF_CODE, 1'b1);
         end
         clear_dictionary();
         prefix = 0;
         prefix_seen = 0;
         return;
      end
      if (!prefix_seen) begin
         prefix = data;
         prefix_seen = 1;
         return;
      end
      key = (prefix << 8) | data;
      if (pair_codes.exists(key)) begin
         prefix = pair_codes[key];
         return;
      end
      push_code(prefix, 1'b0);
      if (next_code < table_codes) begin
         pair_codes[key] = next_code;
         if (next_code == width_limit) begin
            cur_width++;
            width_limit = width_limit << 1;
         end
      end
      if (next_code >= table_codes + RESTART_EXTRA) begin
         clear_dictionary();
      end else begin
         next_code = (next_code + 1) & 17'h1FFFF;
      end
      prefix = data;
   endfunction

   // Offer one item and wait for its transfer.
   task automatic send_item(logic op, logic [7:0] data);
      if ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_data_byte <= data;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      predict_codes(op, data);
      if (op == OP_DATA) bytes_sent++;
   endtask

   // Drain all codes, let the sequencer settle, then write the table size.
   task automatic write_table_bits(logic [4:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_codes.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      table_bits_reg = value;
   endtask

   // One stream of random content; small alphabets give long matches.
   task automatic send_stream(int length);
      int alphabet;
      int base;
      alphabet = ($urandom_range(3) == 0) ? 256 : $urandom_range(1, 6);
      base = $urandom_range(255);
      for (int i = 0; i < length; i++)
         send_item(OP_DATA, 8'((base + $urandom_range(alphabet - 1)) % 256));
      if ($urandom_range(9) != 0) send_item(OP_END, 8'($urandom));
   endtask

   task automatic test_directed();
      write_table_bits(5'd16);
      // An end with no byte seen emits nothing.
      send_item(OP_END, 8'hFF);
      // A single byte stream, at both byte extremes.
      send_item(OP_DATA, 8'h00);
      send_item(OP_END, 8'h00);
      send_item(OP_DATA, 8'hFF);
      send_item(OP_END, 8'h00);
      // Repeated bytes build and hit dictionary entries.
      repeat (10) send_item(OP_DATA, 8'hAA);
      send_item(OP_DATA, 8'h55);
      send_item(OP_DATA, 8'hAA);
      send_item(OP_DATA, 8'hAA);
      send_item(OP_END, 8'h00);
      send_item(OP_END, 8'h00);
   endtask

   task automatic test_random(int items, logic [4:0] tbits, int s_pct, int r_pct);
      int start_count;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      write_table_bits(tbits);
      start_count = bytes_sent;
      while (bytes_sent - start_count < items) send_stream($urandom_range(1, 80));
   endtask

   // The receiver holds off while bytes keep coming, so the core backs up.
   task automatic test_back_pressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_table_bits(5'd13);
      hold_off_cycles = 400;
      repeat (60) send_item(OP_DATA, 8'($urandom));
      send_item(OP_END, 8'h00);
   endtask

   // A long stream of random bytes pushes the code width past 9 bits.
   task automatic test_long_stream();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_table_bits(5'd12);
      repeat (550) send_item(OP_DATA, 8'($urandom));
      send_item(OP_END, 8'h00);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_DATA;
      req_data_byte = 8'h00;
      csr_wr_en = 1'b0;
      csr_wr_data = 5'd0;
      rsp_stall = 1'b0;
      hold_off_cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      cycles = 0;
      errors = 0;
      bytes_sent = 0;
      codes_checked = 0;
      max_width_seen = 0;
      table_bits_reg = TABLE_BITS_RESET;
      prefix = 0;
      prefix_seen = 0;
      clear_dictionary();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(350, 5'd31, 20, 75);
      test_random(350, 5'd0, 75, 20);
      test_random(300, 5'd14, 0, 0);
      test_random(300, 5'd16, 20, 20);
      test_back_pressure();
      test_long_stream();

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_codes.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d bytes and checked %0d codes, widest code %0d bits.",
               bytes_sent, codes_checked, max_width_seen);
      $display("Streams covered several table sizes, idle mixes and a long stall.");
      if (errors == 0 && pending_codes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
hdl/lzwe_pkg.sv
hdl/lzwe_ram.sv
hdl/lzw_variable_width_encoder_core.sv
tb/lzw_variable_width_encoder_core_test.sv
